>>> rtl/core/svema_pkg.sv
package svema_pkg;

    // Filter number format
    localparam int FRAC_BITS   = 22;
    localparam int SAMPLE_BITS = 10;
    localparam int ACC_W       = SAMPLE_BITS + FRAC_BITS;

    // Multiplier operands: weight side and accumulator/sample side
    localparam int K_W    = FRAC_BITS + 1;
    localparam int OPB_W  = (FRAC_BITS > SAMPLE_BITS) ? FRAC_BITS : SAMPLE_BITS;
    localparam int PROD_W = K_W + OPB_W;

    // Port field widths
    localparam int SAMPLE_IN_W = 10;
    localparam int ALPHA_W     = 22;
    localparam int REF_W       = 21;
    localparam int CODE_W      = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 22;

    localparam int DIV_CNT_W = $clog2(REF_W);

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(2097);
    localparam logic [REF_W-1:0]   REF_RESET   = REF_W'(1126400);

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REF   = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SAMPLE,
        ST_MUL_WHOLE,
        ST_MUL_PART,
        ST_COMMIT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_MUL_SAMPLE,
        DP_MUL_WHOLE,
        DP_MUL_PART,
        DP_COMMIT,
        DP_DIV_STEP,
        DP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        logic code_zero;
        logic div_last;
    } t_dp_status;

endpackage

>>> rtl/core/svema_in_if.sv
interface svema_in_if;
    logic                                valid;
    logic                                ready;
    logic [svema_pkg::SAMPLE_IN_W-1:0]   adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> rtl/core/svema_out_if.sv
interface svema_out_if;
    logic                          valid;
    logic                          ready;
    logic [svema_pkg::REF_W-1:0]   supply_millivolts;
    logic [svema_pkg::CODE_W-1:0]  filtered_code;
    logic                          divide_by_zero;

    modport source (output valid, output supply_millivolts, output filtered_code,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input supply_millivolts, input filtered_code,
                    input divide_by_zero, output ready);
endinterface

>>> rtl/core/svema_ctrl.sv
module svema_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    input  svema_pkg::t_dp_status i_status,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output svema_pkg::t_dp_op     o_op
);

    svema_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svema_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = svema_pkg::DP_NOP;
        o_in_ready  = 1'b0;
        case (r_state)
            svema_pkg::ST_IDLE: begin
                // hold off sample beats while reset is applied
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_op    = svema_pkg::DP_CAPTURE;
                    n_state = svema_pkg::ST_MUL_SAMPLE;
                end
            end
            svema_pkg::ST_MUL_SAMPLE: begin
                o_op    = svema_pkg::DP_MUL_SAMPLE;
                n_state = svema_pkg::ST_MUL_WHOLE;
            end
            svema_pkg::ST_MUL_WHOLE: begin
                o_op    = svema_pkg::DP_MUL_WHOLE;
                n_state = svema_pkg::ST_MUL_PART;
            end
            svema_pkg::ST_MUL_PART: begin
                o_op    = svema_pkg::DP_MUL_PART;
                n_state = svema_pkg::ST_COMMIT;
            end
            svema_pkg::ST_COMMIT: begin
                o_op    = svema_pkg::DP_COMMIT;
                n_state = svema_pkg::ST_DIV;
            end
            svema_pkg::ST_DIV: begin
                // skip the divide entirely on a zero code
                if (i_status.code_zero) begin
                    n_state = svema_pkg::ST_OUT;
                end else begin
                    o_op = svema_pkg::DP_DIV_STEP;
                    if (i_status.div_last) begin
                        n_state = svema_pkg::ST_OUT;
                    end
                end
            end
            svema_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_op        = svema_pkg::DP_OUT_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = svema_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = svema_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/svema_dpath.sv
module svema_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [svema_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [svema_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [svema_pkg::SAMPLE_IN_W-1:0]  i_adc_sample,
    input  svema_pkg::t_dp_op                  i_op,
    output svema_pkg::t_dp_status              o_status,
    output logic [svema_pkg::REF_W-1:0]        o_supply_millivolts,
    output logic [svema_pkg::CODE_W-1:0]       o_filtered_code,
    output logic                               o_divide_by_zero
);

    localparam int CMP_W = (svema_pkg::ALPHA_W > svema_pkg::K_W) ?
                           svema_pkg::ALPHA_W : svema_pkg::K_W;
    localparam int SB    = svema_pkg::SAMPLE_BITS;
    localparam int FB    = svema_pkg::FRAC_BITS;

    logic [svema_pkg::ALPHA_W-1:0]   r_alpha;
    logic [svema_pkg::REF_W-1:0]     r_ref;
    logic [svema_pkg::ACC_W-1:0]     r_acc;
    logic [SB-1:0]                   r_sample;
    logic [svema_pkg::ACC_W-1:0]     r_sum;
    logic [svema_pkg::REF_W-1:0]     r_quo;
    logic [SB-1:0]                   r_rem;
    logic [svema_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [svema_pkg::REF_W-1:0]     r_out_mv;
    logic [svema_pkg::CODE_W-1:0]    r_out_code;
    logic                            r_out_dz;

    logic [CMP_W-1:0]              alpha_ext;
    logic [CMP_W-1:0]              one_ext;
    logic [svema_pkg::K_W-1:0]     w_sat;
    logic [svema_pkg::K_W-1:0]     k_rest;
    logic [svema_pkg::K_W-1:0]     opa;
    logic [svema_pkg::OPB_W-1:0]   opb;
    logic [svema_pkg::PROD_W-1:0]  prod;
    logic [svema_pkg::ACC_W-1:0]   term;
    logic [SB-1:0]                 code;
    logic                          code_zero;
    logic [SB:0]                   rem_sh;
    logic                          rem_ge;
    logic [SB:0]                   rem_diff;

    // Clamp the weight to one, then form its complement
    assign alpha_ext = CMP_W'(r_alpha);
    assign one_ext   = CMP_W'(1) << FB;
    assign w_sat     = (alpha_ext > one_ext) ? svema_pkg::K_W'(one_ext)
                                             : svema_pkg::K_W'(alpha_ext);
    assign k_rest    = svema_pkg::K_W'(one_ext) - w_sat;

    assign code      = r_acc[svema_pkg::ACC_W-1:FB];
    assign code_zero = (code == '0);

    // Shared multiplier: weight*sample, rest*whole, rest*fraction
    always_comb begin
        opa  = k_rest;
        opb  = svema_pkg::OPB_W'(r_acc[FB-1:0]);
        case (i_op)
            svema_pkg::DP_MUL_SAMPLE: begin
                opa = w_sat;
                opb = svema_pkg::OPB_W'(r_sample);
            end
            svema_pkg::DP_MUL_WHOLE: begin
                opb = svema_pkg::OPB_W'(code);
            end
            default: begin
                opb = svema_pkg::OPB_W'(r_acc[FB-1:0]);
            end
        endcase
    end

    assign prod = svema_pkg::PROD_W'(opa) * svema_pkg::PROD_W'(opb);
    assign term = (i_op == svema_pkg::DP_MUL_PART) ? svema_pkg::ACC_W'(prod >> FB)
                                                   : svema_pkg::ACC_W'(prod);

    // Restoring divide, one quotient bit per step
    assign rem_sh   = {r_rem, r_quo[svema_pkg::REF_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, code});
    assign rem_diff = rem_sh - {1'b0, code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= svema_pkg::ALPHA_RESET;
            r_ref   <= svema_pkg::REF_RESET;
            r_acc   <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == svema_pkg::CFG_ALPHA)) begin
                r_alpha <= svema_pkg::ALPHA_W'(i_cfg_data);
            end
            if (i_cfg_we && (i_cfg_idx == svema_pkg::CFG_REF)) begin
                r_ref <= svema_pkg::REF_W'(i_cfg_data);
            end
            case (i_op)
                svema_pkg::DP_COMMIT: begin
                    r_acc <= r_sum;
                    r_cnt <= '0;
                end
                svema_pkg::DP_DIV_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            svema_pkg::DP_CAPTURE: begin
                r_sample <= SB'(i_adc_sample);
            end
            svema_pkg::DP_MUL_SAMPLE: begin
                r_sum <= term;
            end
            svema_pkg::DP_MUL_WHOLE, svema_pkg::DP_MUL_PART: begin
                r_sum <= r_sum + term;
            end
            svema_pkg::DP_COMMIT: begin
                r_quo <= r_ref;
                r_rem <= '0;
            end
            svema_pkg::DP_DIV_STEP: begin
                r_rem <= rem_ge ? rem_diff[SB-1:0] : rem_sh[SB-1:0];
                r_quo <= {r_quo[svema_pkg::REF_W-2:0], rem_ge};
            end
            svema_pkg::DP_OUT_LOAD: begin
                r_out_dz   <= code_zero;
                r_out_mv   <= code_zero ? '0 : r_quo;
                r_out_code <= svema_pkg::CODE_W'(code);
            end
            default: begin
            end
        endcase
    end

    assign o_status.code_zero = code_zero;
    assign o_status.div_last  = (r_cnt == svema_pkg::DIV_CNT_W'(svema_pkg::REF_W - 1));

    assign o_supply_millivolts = r_out_mv;
    assign o_filtered_code     = r_out_code;
    assign o_divide_by_zero    = r_out_dz;

endmodule

>>> rtl/core/supply_voltage_ema_monitor_top.sv
// A sample beat is taken only in the idle state: no new sample is taken until
//   the result of the last one is loaded into the output register, and the
//   divide is skipped when the filtered code is zero. Quotients come from the
//   21-step restoring divider; the three filter products share one multiplier.
// Reset (i_rst_n, synchronous, active low): accumulator cleared, registers at
//   their defaults, no result pending; ready as soon as reset is released.
module supply_voltage_ema_monitor_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [svema_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [svema_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    svema_in_if.sink                          i_in_ch,
    svema_out_if.source                       o_out_ch
);

    // Command and status between sequencer and datapath
    svema_pkg::t_dp_op     dp_op;
    svema_pkg::t_dp_status dp_status;

    // Sequencer: take one sample beat, step the filter products, run the
    // divide, then park the result in the output register. A new sample is
    // taken while a finished result still waits on the output side.
    svema_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_status    (dp_status),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_op        (dp_op)
    );

    // Datapath: configuration registers, accumulator, shared multiplier,
    // serial divider and the output register.
    svema_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_adc_sample        (i_in_ch.adc_sample),
        .i_op                (dp_op),
        .o_status            (dp_status),
        .o_supply_millivolts (o_out_ch.supply_millivolts),
        .o_filtered_code     (o_out_ch.filtered_code),
        .o_divide_by_zero    (o_out_ch.divide_by_zero)
    );

    // A zero code always reports zero millivolts
    a_dz_zero_mv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.divide_by_zero) |-> (o_out_ch.supply_millivolts == '0))
        else $error("divide_by_zero beat with nonzero millivolts");

    // The flag matches the reported code
    a_dz_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> (o_out_ch.divide_by_zero == (o_out_ch.filtered_code == '0)))
        else $error("divide_by_zero disagrees with filtered_code");

    // One sample in flight: no second beat right after a taken one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> !i_in_ch.ready)
        else $error("sample taken while previous sample still in work");

    // A result appears only from the output step of the sequencer
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_ch.valid) |-> $past(dp_op == svema_pkg::DP_OUT_LOAD))
        else $error("result valid without an output load");

endmodule

>>> tb/sv/supply_voltage_ema_monitor_top_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the supply voltage EMA monitor.
// Samples go in through a burst/gap driver, results come back through a monitor
// with its own stall pattern, and every result is checked against a local
// model of the fixed-point filter and the divide.
module supply_voltage_ema_monitor_top_test;
    import svema_pkg::*;

    // One result beat as the bench sees it.
    typedef struct packed {
        logic [REF_W-1:0]  millivolts;
        logic [CODE_W-1:0] code;
        logic              div_zero;
    } reading_t;

    // Unity gain of the filter in Q10.22.
    localparam longint unsigned UNITY_WEIGHT = 64'd1 << FRAC_BITS;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port, owned by the sequence block.
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_ALPHA;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Sample side, owned by the driver.
    logic                   drv_valid  = 1'b0;
    logic [SAMPLE_IN_W-1:0] drv_sample = '0;

    // Result side, owned by the monitor.
    logic rx_ready = 1'b0;

    svema_in_if  adc_ch ();
    svema_out_if mv_ch ();

    assign adc_ch.valid      = drv_valid;
    assign adc_ch.adc_sample = drv_sample;
    assign mv_ch.ready       = rx_ready;

    supply_voltage_ema_monitor_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_ch    (adc_ch),
        .o_out_ch   (mv_ch)
    );

    // Period 2 ns.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model copy of the registers and of the filter accumulator.
    logic [ALPHA_W-1:0] alpha_shadow = ALPHA_RESET;
    logic [REF_W-1:0]   ref_shadow   = REF_RESET;
    logic [ACC_W-1:0]   ema_accum    = '0;

    // Samples waiting to be sent, and readings waiting to come back.
    logic [SAMPLE_IN_W-1:0] adc_backlog[$];
    reading_t               expected_readings[$];

    int fault_count = 0;

    // Traffic shaping knobs, set per phase by the sequence block.
    int tx_gap_max   = 0;
    int rx_stall_pct = 0;

    // Long receiver hold-off: the sequence block flips the request, the hold
    // process counts the cycles.
    logic hold_request = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    // Sender burst state, driver only.
    int burst_left = 1;
    int gap_left   = 0;

    // Advance the filter by one sample and work out the reading it yields:
    // acc' = w*sample + floor((1 - w) * acc), then divide the reference by
    // the integer part of acc'.
    function automatic reading_t predict_reading(input logic [SAMPLE_IN_W-1:0] sample);
        longint unsigned weight;
        longint unsigned keep_part;
        reading_t        r;
        weight = 64'(alpha_shadow);
        // Saturate a weight above unity (only possible with fewer fraction bits).
        if (weight > UNITY_WEIGHT) begin
            weight = UNITY_WEIGHT;
        end
        keep_part = (UNITY_WEIGHT - weight) * 64'(ema_accum);
        ema_accum = ACC_W'(weight * 64'(sample) + (keep_part >> FRAC_BITS));
        r.code = ema_accum[ACC_W-1 -: CODE_W];
        if (r.code == '0) begin
            r.millivolts = '0;
            r.div_zero   = 1'b1;
        end else begin
            r.millivolts = REF_W'(ref_shadow / REF_W'(r.code));
            r.div_zero   = 1'b0;
        end
        return r;
    endfunction

    // Driver: send samples from the backlog in bursts with random gaps.
    // Keep valid and data steady until the beat is taken.
    always @(posedge i_clk) begin : drive_samples
        logic [SAMPLE_IN_W-1:0] taken;
        if (!i_rst_n) begin
            drv_valid  <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (drv_valid && adc_ch.ready) begin
                taken = adc_backlog.pop_front();
                expected_readings.push_back(predict_reading(taken));
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(8, 1);
                    gap_left   = (tx_gap_max > 0) ? $urandom_range(tx_gap_max, 0) : 0;
                end
            end else if (!drv_valid && gap_left > 0) begin
                gap_left = gap_left - 1;
            end
            // Drop gaps while the receiver is held off, so the block backs up.
            if (hold_left != 0) begin
                gap_left = 0;
            end
            if (!(drv_valid && !adc_ch.ready)) begin
                if (gap_left == 0 && adc_backlog.size() != 0) begin
                    drv_valid  <= 1'b1;
                    drv_sample <= adc_backlog[0];
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Hold process: count down a long receiver hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: take result beats, check each against the oldest expectation,
    // then pick the next ready from the stall pattern.
    always @(posedge i_clk) begin : check_readings
        reading_t seen;
        reading_t want;
        if (i_rst_n && mv_ch.valid && rx_ready) begin
            seen.millivolts = mv_ch.supply_millivolts;
            seen.code       = mv_ch.filtered_code;
            seen.div_zero   = mv_ch.divide_by_zero;
            if (expected_readings.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS) begin
                    $display("unexpected beat: mv=%0d code=%0d dz=%0b",
                             seen.millivolts, seen.code, seen.div_zero);
                end
            end else begin
                want = expected_readings.pop_front();
                if (seen.millivolts !== want.millivolts || seen.code !== want.code ||
                    seen.div_zero !== want.div_zero) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("bad beat: exp mv=%0d code=%0d dz=%0b, got mv=%0d code=%0d dz=%0b",
                                 want.millivolts, want.code, want.div_zero,
                                 seen.millivolts, seen.code, seen.div_zero);
                    end
                end
            end
        end
        rx_ready <= i_rst_n && (hold_left == 0) && ($urandom_range(99, 0) >= rx_stall_pct);
    end

    // Write one register while the block is idle, and mirror it in the model.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ALPHA) begin
            alpha_shadow = data[ALPHA_W-1:0];
        end else if (idx == CFG_REF) begin
            ref_shadow = data[REF_W-1:0];
        end
    endtask

    // Hold until every sample is sent and every reading is back.
    task automatic drain_readings();
        while (adc_backlog.size() != 0 || expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_samples(input logic [SAMPLE_IN_W-1:0] list[]);
        foreach (list[k]) begin
            adc_backlog.push_back(list[k]);
        end
    endtask

    initial begin : run_sequence
        int                     level;
        int                     pick;
        int                     value;
        logic [CFG_DATA_W-1:0]  data;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        // Defaults: a zero code first, then the slow climb from an empty filter.
        queue_samples('{10'd0, 10'd1023, 10'd1023, 10'd1023});
        drain_readings();

        // Weight near unity: the code tracks the sample; zero sample gives a
        // zero code and the divide is skipped.
        write_reg(CFG_ALPHA, CFG_DATA_W'(22'h3FFFFF));
        queue_samples('{10'd1023, 10'd0, 10'd1, 10'h155, 10'h2AA, 10'd512, 10'd1023});
        drain_readings();

        // Weight zero: the accumulator must hold its value.
        write_reg(CFG_ALPHA, '0);
        queue_samples('{10'd0, 10'd17, 10'd1023});
        drain_readings();

        // Reference zero with a nonzero code, then a zero code.
        write_reg(CFG_ALPHA, CFG_DATA_W'(22'h3FFFFF));
        write_reg(CFG_REF, '0);
        queue_samples('{10'd5, 10'd0});
        drain_readings();

        // Reference at full scale, written with the unused top bit set;
        // smallest weight.
        write_reg(CFG_REF, CFG_DATA_W'(22'h3FFFFF));
        queue_samples('{10'd1, 10'd1023});
        drain_readings();
        write_reg(CFG_ALPHA, CFG_DATA_W'(1));
        queue_samples('{10'd1023, 10'd0, 10'd1023});
        drain_readings();

        // Random part: phases with fresh settings and traffic shapes.
        for (int phase = 0; phase < 8; phase++) begin
            pick = $urandom_range(6, 0);
            case (pick)
                0: data = CFG_DATA_W'(1);
                1: data = CFG_DATA_W'(22'h3FFFFF);
                2: data = CFG_DATA_W'($urandom_range(4095, 1));
                3: data = CFG_DATA_W'($urandom());
                4: data = CFG_DATA_W'(ALPHA_RESET);
                5: data = CFG_DATA_W'($urandom_range(22'h3FFFFF, 22'h100000));
                default: data = CFG_DATA_W'($urandom_range(22'h0FFFFF, 22'h10000));
            endcase
            write_reg(CFG_ALPHA, data);
            pick = $urandom_range(4, 0);
            case (pick)
                0: data = CFG_DATA_W'(REF_RESET);
                1: data = CFG_DATA_W'($urandom());
                2: data = CFG_DATA_W'($urandom_range(2047, 1));
                3: data = CFG_DATA_W'(21'h1FFFFF);
                default: data = CFG_DATA_W'($urandom_range(21'h1FFFFF, 21'h10000));
            endcase
            write_reg(CFG_REF, data);

            // Every third phase runs without sender gaps; one in four without
            // receiver stalls.
            tx_gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(40, 5);
            rx_stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(70, 10);

            // Mostly a noisy steady level that drifts now and then; some
            // zeros, full-scale and fully random samples mixed in.
            level = $urandom_range(1023, 0);
            for (int n = 0; n < 250; n++) begin
                pick = $urandom_range(15, 0);
                if (pick == 15) begin
                    level = $urandom_range(1023, 0);
                end
                if (pick < 2) begin
                    value = 0;
                end else if (pick == 2) begin
                    value = 1023;
                end else if (pick < 7) begin
                    value = $urandom_range(1023, 0);
                end else begin
                    value = level + $urandom_range(32, 0) - 16;
                    value = (value < 0) ? 0 : ((value > 1023) ? 1023 : value);
                end
                adc_backlog.push_back(SAMPLE_IN_W'(value));
            end

            // In one phase hold the receiver off while the sender keeps going.
            if (phase == 3) begin
                repeat (20) @(posedge i_clk);
                hold_request = ~hold_request;
            end
            drain_readings();
        end

        // Let any stray beat show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (fault_count == 0 && expected_readings.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: a correct run ends far sooner.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/core/svema_pkg.sv
rtl/core/svema_in_if.sv
rtl/core/svema_out_if.sv
rtl/core/svema_ctrl.sv
rtl/core/svema_dpath.sv
rtl/core/supply_voltage_ema_monitor_top.sv
tb/sv/supply_voltage_ema_monitor_top_test.sv
